// ----- design/mlfq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the multilevel feedback scheduler.
// No dependencies; used by the interfaces, the controller and the datapath.
package mlfq_pkg;

    localparam int unsigned ID_W    = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CLK_W   = 20;
    localparam int unsigned OVH_W   = 8;
    localparam int unsigned SLICE_W = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CLK_W-1:0]   TICK        = 20'd16;
    localparam logic [SLICE_W-1:0] MAX_QUANTUM = 4'd8;
    localparam int unsigned        MAX_SHIFT_LEVEL = 3;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_STEP    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWITCH_OVERHEAD = 1'b0,
        REG_DOUBLING_QUANTA = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_WAIT,
        S_LD_CHK,
        S_SCHED,
        S_DISP_WAIT,
        S_DISP_TAKE,
        S_RUN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] arrival;
        logic [TICK_W-1:0] service;
    } t_pend;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] remaining;
    } t_lvl_ent;

    typedef struct packed {
        logic accept;
        logic load_pop;
        logic sched;
        logic take;
        logic run;
    } t_cmd;

    typedef struct packed {
        logic is_step;
        logic arrival_ok;
        logic want_dispatch;
    } t_status;

endpackage

// ----- design/mlfq_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: job input, result output and configuration write.
// Depends on mlfq_pkg for field widths.
interface mlfq_in_if import mlfq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [ID_W-1:0]     job_id;
    logic [TICK_W-1:0]   arrival_tick;
    logic [TICK_W-1:0]   service_ticks;
    modport source (output valid, action, job_id, arrival_tick, service_ticks, input ready);
    modport sink   (input valid, action, job_id, arrival_tick, service_ticks, output ready);
endinterface

interface mlfq_out_if import mlfq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   running_id;
    logic              is_idle;
    logic              job_done;
    logic [CLK_W-1:0]  finish_time;
    logic              dropped;
    modport source (output valid, running_id, is_idle, job_done, finish_time, dropped,
                    input ready);
    modport sink   (input valid, running_id, is_idle, job_done, finish_time, dropped,
                    output ready);
endinterface

interface mlfq_cfg_if import mlfq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [OVH_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/mlfq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the scheduler step sequence.
// Depends on mlfq_pkg; drives mlfq_dp through t_cmd and reads t_status.
module mlfq_ctrl import mlfq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_second     = 1'b0;
                    n_state      = i_st.is_step ? S_LD_WAIT : S_OUT;
                end
            end
            S_LD_WAIT: n_state = S_LD_CHK;
            S_LD_CHK: begin
                if (i_st.arrival_ok) begin
                    o_cmd.load_pop = 1'b1;
                    n_state        = S_LD_WAIT;
                end else begin
                    n_state = r_second ? S_DISP_WAIT : S_SCHED;
                end
            end
            S_SCHED: begin
                o_cmd.sched = 1'b1;
                if (i_st.want_dispatch) begin
                    n_second = 1'b1;
                    n_state  = S_LD_WAIT;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_DISP_WAIT: n_state = S_DISP_TAKE;
            S_DISP_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- design/mlfq_dp.sv -----
`timescale 1ns / 1ps
// Datapath: pending FIFO memory, level queue memory, active job and clock.
// Depends on mlfq_pkg; sequenced by mlfq_ctrl.
module mlfq_dp import mlfq_pkg::*; #(
    parameter int unsigned LEVELS        = 4,
    parameter int unsigned LEVEL_DEPTH   = 32,
    parameter int unsigned PENDING_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    input  logic                 i_action,
    input  logic [ID_W-1:0]      i_job_id,
    input  logic [TICK_W-1:0]    i_arrival_tick,
    input  logic [TICK_W-1:0]    i_service_ticks,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OVH_W-1:0]     i_cfg_data,
    output logic [ID_W-1:0]      o_running_id,
    output logic                 o_is_idle,
    output logic                 o_job_done,
    output logic [CLK_W-1:0]     o_finish_time,
    output logic                 o_dropped
);
    localparam int unsigned PW  = $clog2(PENDING_DEPTH);
    localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned QW  = $clog2(LEVEL_DEPTH);
    localparam int unsigned QCW = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned LW  = $clog2(LEVELS);
    localparam int unsigned AW  = $clog2(LEVELS * LEVEL_DEPTH);

    logic [OVH_W-1:0] r_overhead;
    logic             r_doubling;

    t_pend    r_pmem [PENDING_DEPTH];
    t_pend    r_prd;
    logic [PW-1:0]  r_phead;
    logic [PCW-1:0] r_pcount;

    t_lvl_ent r_lmem [LEVELS * LEVEL_DEPTH];
    t_lvl_ent r_lrd;
    logic [QW-1:0]  r_lhead  [LEVELS];
    logic [QCW-1:0] r_lcount [LEVELS];

    logic [ID_W-1:0]    r_aid;
    logic [TICK_W-1:0]  r_arem;
    logic [LW-1:0]      r_alvl;
    logic [SLICE_W-1:0] r_slice;
    logic [CLK_W-1:0]   r_clock;
    logic               r_is_step;

    logic [ID_W-1:0]  r_ran;
    logic             r_idle;
    logic             r_done;
    logic [CLK_W-1:0] r_fin;
    logic             r_drop;

    function automatic logic [SLICE_W-1:0] quantum(input logic [LW-1:0] lvl,
                                                   input logic dbl);
        logic [SLICE_W-1:0] q;
        q = 4'd1;
        if (dbl) begin
            if (int'(lvl) >= MAX_SHIFT_LEVEL) q = MAX_QUANTUM;
            else q = SLICE_W'(1) << lvl;
        end
        return q;
    endfunction

    // lowest non-empty level
    logic          any_rdy;
    logic [LW-1:0] fr;
    always_comb begin
        any_rdy = 1'b0;
        fr      = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_lcount[i] != '0) begin
                any_rdy = 1'b1;
                fr      = LW'(i);
            end
        end
    end

    // scheduling decisions
    logic          pre, expd, dem;
    logic [LW-1:0] nxt;
    always_comb begin
        pre  = (r_aid != '0) && any_rdy && (fr < r_alvl);
        expd = (r_aid != '0) && !pre && (r_slice == '0);
        dem  = expd && any_rdy;
        nxt  = (r_alvl == LW'(LEVELS - 1)) ? r_alvl : r_alvl + LW'(1);
    end

    logic arr_ok;
    assign arr_ok = (r_pcount != '0) && ({r_prd.arrival, 4'b0000} <= r_clock);

    assign o_st.is_step       = i_action;
    assign o_st.arrival_ok    = arr_ok;
    assign o_st.want_dispatch = ((r_aid == '0) && any_rdy) || pre || dem;

    // level write port
    logic          lw_req, lw_front;
    logic [LW-1:0] lw_lvl;
    t_lvl_ent      lw_ent;
    always_comb begin
        lw_req   = 1'b0;
        lw_front = 1'b0;
        lw_lvl   = '0;
        lw_ent   = '{id: r_aid, remaining: r_arem};
        if (i_cmd.load_pop) begin
            lw_req = 1'b1;
            lw_ent = '{id: r_prd.id, remaining: r_prd.service};
        end else if (i_cmd.sched && pre) begin
            lw_req   = 1'b1;
            lw_front = 1'b1;
            lw_lvl   = r_alvl;
        end else if (i_cmd.sched && dem) begin
            lw_req = 1'b1;
            lw_lvl = nxt;
        end
    end

    logic [QCW:0]  lw_sum;
    logic [QW-1:0] lw_pos;
    logic          lw_full;
    always_comb begin
        lw_full = (r_lcount[lw_lvl] == QCW'(LEVEL_DEPTH));
        lw_sum  = (QCW+1)'(r_lhead[lw_lvl]) + (QCW+1)'(r_lcount[lw_lvl]);
        if (lw_front) begin
            lw_pos = (r_lhead[lw_lvl] == '0) ? QW'(LEVEL_DEPTH - 1)
                                               : r_lhead[lw_lvl] - QW'(1);
        end else if (lw_sum >= (QCW+1)'(LEVEL_DEPTH)) begin
            lw_pos = QW'(lw_sum - (QCW+1)'(LEVEL_DEPTH));
        end else begin
            lw_pos = QW'(lw_sum);
        end
    end

    logic [AW-1:0] lw_addr, lr_addr;
    assign lw_addr = AW'(lw_lvl) * AW'(LEVEL_DEPTH) + AW'(lw_pos);
    assign lr_addr = AW'(fr) * AW'(LEVEL_DEPTH) + AW'(r_lhead[fr]);

    always_ff @(posedge i_clk) begin
        if (lw_req && !lw_full) r_lmem[lw_addr] <= lw_ent;
        r_lrd <= r_lmem[lr_addr];
    end

    // pending write port
    logic [PCW:0]  p_sum;
    logic [PW-1:0] p_tail;
    logic          p_full, enq_valid;
    always_comb begin
        p_full    = (r_pcount == PCW'(PENDING_DEPTH));
        enq_valid = (i_job_id != '0) && (i_service_ticks != '0);
        p_sum     = (PCW+1)'(r_phead) + (PCW+1)'(r_pcount);
        if (p_sum >= (PCW+1)'(PENDING_DEPTH)) p_tail = PW'(p_sum - (PCW+1)'(PENDING_DEPTH));
        else p_tail = PW'(p_sum);
    end

    logic p_we;
    assign p_we = i_cmd.accept && (i_action == ACT_ENQUEUE) && enq_valid && !p_full;

    always_ff @(posedge i_clk) begin
        if (p_we) r_pmem[p_tail] <= '{id: i_job_id, arrival: i_arrival_tick,
                                      service: i_service_ticks};
        r_prd <= r_pmem[r_phead];
    end

    logic [TICK_W-1:0] rem_dec;
    logic [CLK_W-1:0]  clk_tick;
    assign rem_dec  = r_arem - TICK_W'(1);
    assign clk_tick = r_clock + TICK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overhead <= '0;
            r_doubling <= 1'b1;
            r_phead    <= '0;
            r_pcount   <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_lhead[i]  <= '0;
                r_lcount[i] <= '0;
            end
            r_aid      <= '0;
            r_arem     <= '0;
            r_alvl     <= '0;
            r_slice    <= '0;
            r_clock    <= '0;
            r_is_step  <= 1'b0;
            r_ran      <= '0;
            r_idle     <= 1'b0;
            r_done     <= 1'b0;
            r_fin      <= '0;
            r_drop     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_SWITCH_OVERHEAD: r_overhead <= i_cfg_data;
                    REG_DOUBLING_QUANTA: r_doubling <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (lw_req) begin
                if (lw_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_lcount[lw_lvl] <= r_lcount[lw_lvl] + QCW'(1);
                    if (lw_front) r_lhead[lw_lvl] <= lw_pos;
                end
            end
            if (i_cmd.accept) begin
                r_is_step <= i_action;
                r_ran     <= '0;
                r_idle    <= 1'b0;
                r_done    <= 1'b0;
                r_fin     <= '0;
                r_drop    <= (i_action == ACT_ENQUEUE) && enq_valid && p_full;
                if (p_we) r_pcount <= r_pcount + PCW'(1);
            end
            if (i_cmd.load_pop) begin
                r_phead  <= (r_phead == PW'(PENDING_DEPTH - 1)) ? '0 : r_phead + PW'(1);
                r_pcount <= r_pcount - PCW'(1);
            end
            if (i_cmd.sched) begin
                if (pre) begin
                    r_aid   <= '0;
                    r_slice <= '0;
                end else if (dem) begin
                    r_aid <= '0;
                end else if (expd) begin
                    r_alvl  <= nxt;
                    r_slice <= quantum(nxt, r_doubling);
                end
                if (o_st.want_dispatch) r_clock <= r_clock + CLK_W'(r_overhead);
            end
            if (i_cmd.take) begin
                r_aid       <= r_lrd.id;
                r_arem      <= r_lrd.remaining;
                r_alvl      <= fr;
                r_slice     <= quantum(fr, r_doubling);
                r_lhead[fr] <= (r_lhead[fr] == QW'(LEVEL_DEPTH - 1)) ? '0
                                                                      : r_lhead[fr] + QW'(1);
                r_lcount[fr] <= r_lcount[fr] - QCW'(1);
            end
            if (i_cmd.run) begin
                r_clock <= clk_tick;
                if (r_aid == '0) begin
                    r_idle <= 1'b1;
                end else begin
                    r_ran  <= r_aid;
                    r_arem <= rem_dec;
                    if (r_slice != '0) r_slice <= r_slice - SLICE_W'(1);
                    if (rem_dec == '0) begin
                        r_done  <= 1'b1;
                        r_fin   <= clk_tick;
                        r_aid   <= '0;
                        r_slice <= '0;
                    end
                end
            end
        end
    end

    assign o_running_id  = r_ran;
    assign o_is_idle     = r_idle && r_is_step;
    assign o_job_done    = r_done;
    assign o_finish_time = r_fin;
    assign o_dropped     = r_drop;
endmodule

// ----- design/multilevel_feedback_scheduler.sv -----
`timescale 1ns / 1ps
// Four-level feedback scheduler top: controller, datapath and channel ports.
// An enqueue beat goes straight to its result. A run beat moves each due arrival,
// schedules, dispatches if due and runs one tick; next beat taken after the result.
// The pending FIFO and level queue memories, with one registered read port
// each, set the cost of every arrival move. Synchronous active-low reset
// clears pointers, counts, the active job and the clock; no clearing pass.
module multilevel_feedback_scheduler import mlfq_pkg::*; #(
    parameter int unsigned LEVELS        = 4,
    parameter int unsigned LEVEL_DEPTH   = 32,
    parameter int unsigned PENDING_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mlfq_in_if.sink    i_job,
    mlfq_out_if.source o_res,
    mlfq_cfg_if.sink   i_cfg
);
    t_cmd    cmd;
    t_status st;

    assign i_cfg.ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_job.valid),
        .o_in_ready  (i_job.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    mlfq_dp #(
        .LEVELS        (LEVELS),
        .LEVEL_DEPTH   (LEVEL_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_action        (i_job.action),
        .i_job_id        (i_job.job_id),
        .i_arrival_tick  (i_job.arrival_tick),
        .i_service_ticks (i_job.service_ticks),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_running_id    (o_res.running_id),
        .o_is_idle       (o_res.is_idle),
        .o_job_done      (o_res.job_done),
        .o_finish_time   (o_res.finish_time),
        .o_dropped       (o_res.dropped)
    );

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_job.ready) else $error("input taken while result pending");

    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.job_done) |-> (!o_res.is_idle && o_res.running_id != '0))
        else $error("completion without a running job");

    a_enqueue_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.valid && i_job.ready && i_job.action == ACT_ENQUEUE) |=>
        (o_res.valid && o_res.running_id == '0 && !o_res.job_done))
        else $error("enqueue result malformed");
endmodule
